[rtl/hsv2rgb_pkg.sv]
`timescale 1ns / 1ps
package hsv2rgb_pkg;

  localparam int FB        = 16;
  localparam int HUE_W     = FB;
  localparam int FRAC_W    = FB + 1;
  localparam int IN_BITS   = HUE_W + 2 * FRAC_W;
  localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
  localparam int CH_W      = 8;
  localparam int RGB_W     = 3 * CH_W;

  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] sat;
    logic [FRAC_W-1:0] bri;
  } hsv_t;

  typedef struct packed {
    sector_t           sector;
    logic [FB-1:0]     f;
    logic [FB:0]       fc;
    logic [FB:0]       s;
    logic [FB:0]       v;
  } prep_t;

  typedef struct packed {
    sector_t     sector;
    logic [FB:0] p;
    logic [FB:0] q;
    logic [FB:0] t;
    logic [FB:0] v;
  } pqt_t;

endpackage

[rtl/hsv2rgb_prep.sv]
`timescale 1ns / 1ps
module hsv2rgb_prep (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsv2rgb_pkg::hsv_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hsv2rgb_pkg::prep_t  out_data
);
  import hsv2rgb_pkg::*;

  logic [HUE_W+2:0] h6;
  logic [FB:0]      s_clamp;
  logic [FB:0]      v_clamp;
  logic [FB-1:0]    frac;
  prep_t            data_next;

  always_comb begin
    h6      = {in_data.hue, 2'b00} + {1'b0, in_data.hue, 1'b0};
    frac    = h6[FB-1:0];
    s_clamp = (in_data.sat > ONE) ? ONE : in_data.sat;
    v_clamp = (in_data.bri > ONE) ? ONE : in_data.bri;
    data_next.sector = sector_t'(h6[HUE_W+2:HUE_W]);
    data_next.f      = frac;
    data_next.fc     = ONE - {1'b0, frac};
    data_next.s      = s_clamp;
    data_next.v      = v_clamp;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= data_next;
    end
  end

endmodule

[rtl/hsv2rgb_mul.sv]
`timescale 1ns / 1ps
module hsv2rgb_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hsv2rgb_pkg::prep_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hsv2rgb_pkg::pqt_t   out_data
);
  import hsv2rgb_pkg::*;

  // stage A: s-products and p
  logic [2*FB:0]   fs_full;
  logic [2*FB+1:0] gs_full;
  logic [2*FB+1:0] p_full;
  logic            a_valid;
  logic            a_ready;
  sector_t         a_sector;
  logic [FB:0]     a_v;
  logic [FB:0]     a_p;
  logic [FB:0]     a_omf;
  logic [FB:0]     a_omg;

  // stage B: q and t
  logic [2*FB+1:0] q_full;
  logic [2*FB+1:0] t_full;

  always_comb begin
    fs_full = in_data.f * in_data.s;
    gs_full = in_data.fc * in_data.s;
    p_full  = in_data.v * (ONE - in_data.s);
    q_full  = a_v * a_omf;
    t_full  = a_v * a_omg;
  end

  assign a_ready  = !out_valid || out_ready;
  assign in_ready = !a_valid || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid <= in_valid;
      end
      if (a_ready) begin
        out_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_sector <= in_data.sector;
      a_v      <= in_data.v;
      a_p      <= p_full[2*FB:FB];
      a_omf    <= ONE - fs_full[2*FB:FB];
      a_omg    <= ONE - gs_full[2*FB:FB];
    end
    if (a_ready && a_valid) begin
      out_data.sector <= a_sector;
      out_data.v      <= a_v;
      out_data.p      <= a_p;
      out_data.q      <= q_full[2*FB:FB];
      out_data.t      <= t_full[2*FB:FB];
    end
  end

endmodule

[rtl/hsv2rgb_pack.sv]
`timescale 1ns / 1ps
module hsv2rgb_pack (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  hsv2rgb_pkg::pqt_t      in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [hsv2rgb_pkg::RGB_W-1:0] out_data
);
  import hsv2rgb_pkg::*;

  function automatic logic [CH_W-1:0] to_byte(input logic [FB:0] x);
    logic [FB+8:0] scaled;
    begin
      // x * 255 = (x << 8) - x
      scaled  = {x, 8'd0} - {8'd0, x};
      to_byte = scaled[FB+7:FB];
    end
  endfunction

  logic [FB:0]      r;
  logic [FB:0]      g;
  logic [FB:0]      b;
  logic [RGB_W-1:0] rgb_next;

  always_comb begin
    case (in_data.sector)
      SEC_RED_YEL: begin r = in_data.v; g = in_data.t; b = in_data.p; end
      SEC_YEL_GRN: begin r = in_data.q; g = in_data.v; b = in_data.p; end
      SEC_GRN_CYN: begin r = in_data.p; g = in_data.v; b = in_data.t; end
      SEC_CYN_BLU: begin r = in_data.p; g = in_data.q; b = in_data.v; end
      SEC_BLU_MAG: begin r = in_data.t; g = in_data.p; b = in_data.v; end
      default:     begin r = in_data.v; g = in_data.p; b = in_data.q; end
    endcase
    rgb_next = {to_byte(r), to_byte(g), to_byte(b)};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_data <= rgb_next;
    end
  end

endmodule

[rtl/hsv_to_rgb_converter_unit.sv]
`timescale 1ns / 1ps
// HSV to packed RGB pixel converter.
// Input stream s_*: one HSV colour per item. Output stream m_*: one packed
// 24-bit RGB pixel per item, in input order.
// Hue is a fraction of a full turn; saturation and brightness are 1.16
// fractions where 0x10000 is 1.0, larger values clamp to 1.0.
// Four register stages: hue split and clamping, the s-products and p,
// the q and t products, then sector select, 8-bit scaling and the output
// register. One item per clock is sustained while m_tready stays high,
// set by the one-item-per-stage pipeline.
// Each stage has its own valid bit and takes a new item whenever it is
// empty or its item moves on, so bubbles collapse while m_tready is low.
// When the receiver stalls, the pixel in the output register holds and up
// to three more items are taken before s_tready drops.
// Synchronous reset empties every stage; no item is pending afterwards.
module hsv_to_rgb_converter_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // hue [15:0], saturation [32:16], brightness [49:33], zero fill above
  input  logic [hsv2rgb_pkg::IN_TDATA_W-1:0]  s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // packed_rgb [23:0]: blue [7:0], green [15:8], red [23:16]
  output logic [hsv2rgb_pkg::RGB_W-1:0]       m_tdata
);
  import hsv2rgb_pkg::*;

  hsv_t  in_hsv;
  prep_t prep_data;
  logic  prep_valid;
  logic  prep_ready;
  pqt_t  pqt_data;
  logic  pqt_valid;
  logic  pqt_ready;

  always_comb begin
    in_hsv.hue = s_tdata[HUE_W-1:0];
    in_hsv.sat = s_tdata[HUE_W+FRAC_W-1:HUE_W];
    in_hsv.bri = s_tdata[IN_BITS-1:HUE_W+FRAC_W];
  end

  hsv2rgb_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (in_hsv),
    .out_valid (prep_valid),
    .out_ready (prep_ready),
    .out_data  (prep_data)
  );

  hsv2rgb_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (prep_valid),
    .in_ready  (prep_ready),
    .in_data   (prep_data),
    .out_valid (pqt_valid),
    .out_ready (pqt_ready),
    .out_data  (pqt_data)
  );

  hsv2rgb_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pqt_valid),
    .in_ready  (pqt_ready),
    .in_data   (pqt_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

[rtl/hsv2rgb_checker.sv]
`timescale 1ns / 1ps
module hsv2rgb_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic [hsv2rgb_pkg::IN_TDATA_W-1:0]  s_tdata,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [hsv2rgb_pkg::RGB_W-1:0]       m_tdata
);
  import hsv2rgb_pkg::*;

  logic acc_black;
  logic acc_white;

  assign acc_black = s_tvalid && s_tready &&
                     (s_tdata[IN_BITS-1:HUE_W+FRAC_W] == '0);
  assign acc_white = s_tvalid && s_tready &&
                     (s_tdata[HUE_W+FRAC_W-1:HUE_W] == '0) &&
                     (s_tdata[IN_BITS-1:HUE_W+FRAC_W] == ONE);

  // hold a stalled pixel
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled pixel changed");

  // an empty output stage lets the whole pipe accept
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  // zero brightness gives black when the output is not stalled
  a_black: assert property (@(posedge clk) disable iff (rst)
    acc_black ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid && (m_tdata == '0))
    else $error("black pixel wrong or late");

  // zero saturation at full brightness gives white
  a_white: assert property (@(posedge clk) disable iff (rst)
    acc_white ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid && (m_tdata == '1))
    else $error("white pixel wrong or late");

endmodule

bind hsv_to_rgb_converter_unit hsv2rgb_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
  import hsv2rgb_pkg::*;

  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int IDLE_PCT     = 21;
  localparam int DRAIN_CYCLES = 12;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [RGB_W-1:0]       m_tdata;

  hsv_t             colors_pending[$];
  logic [RGB_W-1:0] pixels_expected[$];
  int               colors_issued = 0;
  int               colors_taken = 0;
  int               pixels_checked = 0;
  int               mismatches = 0;
  int               cycle_cnt = 0;

  hsv_to_rgb_converter_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // 1.16 product, truncated
  function automatic logic [FB:0] frac_mul(logic [FB:0] a, logic [FB:0] b);
    logic [2*FB+1:0] prod;
    prod = a * b;
    return prod[2*FB:FB];
  endfunction

  // floor(x * 255) with x in 1.16
  function automatic logic [CH_W-1:0] to_channel(logic [FB:0] x);
    logic [FB+8:0] w;
    w = x * 9'd255;
    return w[FB+7:FB];
  endfunction

  function automatic logic [RGB_W-1:0] hsv_pixel(hsv_t c);
    logic [FB+2:0] h6;
    logic [FB-1:0] f;
    logic [FB:0]   s, v, p, q, t, r, g, b;
    sector_t       sec;
    h6  = c.hue * 3'd6;
    sec = sector_t'(h6[FB+2:FB]);
    f   = h6[FB-1:0];
    s   = (c.sat > ONE) ? ONE : c.sat;
    v   = (c.bri > ONE) ? ONE : c.bri;
    p   = frac_mul(v, ONE - s);
    q   = frac_mul(v, ONE - frac_mul({1'b0, f}, s));
    t   = frac_mul(v, ONE - frac_mul(ONE - {1'b0, f}, s));
    case (sec)
      SEC_RED_YEL: begin r = v; g = t; b = p; end
      SEC_YEL_GRN: begin r = q; g = v; b = p; end
      SEC_GRN_CYN: begin r = p; g = v; b = t; end
      SEC_CYN_BLU: begin r = p; g = q; b = v; end
      SEC_BLU_MAG: begin r = t; g = p; b = v; end
      default:     begin r = v; g = p; b = q; end
    endcase
    return {to_channel(r), to_channel(g), to_channel(b)};
  endfunction

  // no idling on either side while this window of items goes through
  function automatic bit take_break();
    if (colors_taken >= 500 && colors_taken < 800)
      return 1'b0;
    return $urandom_range(99, 0) < IDLE_PCT;
  endfunction

  task automatic add_color(int hue, int sat, int bri);
    hsv_t c;
    c.hue = hue[HUE_W-1:0];
    c.sat = sat[FRAC_W-1:0];
    c.bri = bri[FRAC_W-1:0];
    colors_pending.push_back(c);
  endtask

  function automatic int rand_frac();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 8)
      return 32'h10000;
    if (pick < 12)
      return 0;
    if (pick < 37)
      return $urandom_range(131071, 0);
    return $urandom_range(65536, 0);
  endfunction

  // Driver: present the next item once the current one is taken
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || colors_taken == colors_issued)) begin
      if (colors_issued < colors_pending.size() && !take_break()) begin
        s_tdata  <= IN_TDATA_W'({colors_pending[colors_issued].bri,
                                 colors_pending[colors_issued].sat,
                                 colors_pending[colors_issued].hue});
        s_tvalid <= 1'b1;
        colors_issued <= colors_issued + 1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= rst ? 1'b0 : !take_break();
  end

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      pixels_expected.push_back(hsv_pixel(colors_pending[colors_taken]));
      colors_taken <= colors_taken + 1;
    end
  end

  // Monitor: compare each pixel with the oldest expectation
  always @(posedge clk) begin
    logic [RGB_W-1:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pixels_expected.size() == 0) begin
        $error("unexpected pixel: packed_rgb actual %06h", m_tdata);
        mismatches <= mismatches + 1;
      end else begin
        want = pixels_expected.pop_front();
        if (m_tdata !== want) begin
          $error("packed_rgb mismatch: expected %06h actual %06h", want, m_tdata);
          mismatches <= mismatches + 1;
        end
        pixels_checked <= pixels_checked + 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    // black, saturated red, top of the hue range
    add_color(0, 0, 0);
    add_color(0, 32'h10000, 32'h10000);
    add_color(65535, 32'h10000, 32'h10000);
    add_color(65535, 65535, 65535);
    // both sides of every sector boundary
    add_color(10922, 32'h10000, 32'h10000);
    add_color(10923, 32'h10000, 32'h10000);
    add_color(21845, 65535, 65535);
    add_color(21846, 65535, 65535);
    add_color(32767, 32'h10000, 50000);
    add_color(32768, 32'h10000, 50000);
    add_color(43690, 40000, 32'h10000);
    add_color(43691, 40000, 32'h10000);
    add_color(54613, 32'h10000, 32'h10000);
    add_color(54614, 32'h10000, 32'h10000);
    // gray: no saturation
    add_color(12345, 0, 50000);
    add_color(60000, 0, 32'h10000);
    // saturation above one clamps
    add_color(5000, 32'h10001, 32'h10000);
    add_color(5000, 131071, 40000);
    // brightness above one clamps, and a near-black colour
    add_color(30000, 30000, 32'h10001);
    add_color(45000, 131071, 131071);
    add_color(21000, 1, 1);
    for (int i = 0; i < RANDOM_ITEMS; i++)
      add_color($urandom_range(65535, 0), rand_frac(), rand_frac());

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (!(colors_taken == colors_pending.size() && pixels_expected.size() == 0))
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("converted %0d HSV items, checked %0d pixels in %0d cycles",
             colors_taken, pixels_checked, cycle_cnt);
    $display("all six hue sectors, clamped and extreme saturation and brightness");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
